// ----- rtl/pixel_to_ground_plane_projection_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the projection core RTL.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_GROUND_PLANE_PROJECTION_CORE_ASSERT_SVH
`define PIXEL_TO_GROUND_PLANE_PROJECTION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PGP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define PGP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `PGP_ASSERT(lbl, clk, rstn, !(expr), msg)
`else
`define PGP_ASSERT(lbl, clk, rstn, prop, msg)
`define PGP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ----- rtl/pgp_pkg.sv -----
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared types and constants of the ground plane projection core.
// ----------------------------------------------------------------------------
package pgp_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int FOC_W  = 20;
  localparam int CTR_W  = 16;
  localparam int HGT_W  = 12;
  localparam int NUMF_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int QUO_W  = 24;
  localparam int FWD_W  = 23;
  localparam int LAT_W  = 24;
  localparam int ST_W   = 2;

  localparam logic [FOC_W-1:0] FOCAL_X_RST = 20'd8192;
  localparam logic [FOC_W-1:0] FOCAL_Y_RST = 20'd8192;
  localparam logic [CTR_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [CTR_W-1:0] CENTER_Y_RST = 16'd3840;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 12'd527;

  localparam logic [QUO_W-1:0] FWD_MAX = 24'd8388607;
  localparam logic [QUO_W-1:0] LAT_POS_MAX = 24'd8388607;
  localparam logic [QUO_W-1:0] LAT_NEG_MAX = 24'd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_READY = 3'd0,
    CFG_FOCAL_X      = 3'd1,
    CFG_FOCAL_Y      = 3'd2,
    CFG_CENTER_X     = 3'd3,
    CFG_CENTER_Y     = 3'd4,
    CFG_HEIGHT       = 3'd5
  } cfg_idx_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_HORIZON = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    logic             cam_rdy;
    logic [FOC_W-1:0] fx;
    logic [FOC_W-1:0] fy;
    logic [CTR_W-1:0] cx;
    logic [CTR_W-1:0] cy;
    logic [HGT_W-1:0] h;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic hz;
    logic du_pos;
  } ctl_t;

endpackage

// ----- rtl/pgp_front.sv -----
// ----------------------------------------------------------------------------
// pgp_front
// Offset, horizon test and operand products ahead of the dividers.
// ----------------------------------------------------------------------------
module pgp_front #(
  parameter int PIXEL_BITS = pgp_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [PIXEL_BITS-1:0] pix_u,
  input  logic [PIXEL_BITS-1:0] pix_v,
  input  pgp_pkg::cfg_t         cfg,
  output pgp_pkg::ctl_t         ctl,
  output logic [pgp_pkg::NUMF_W-1:0] num_f,
  output logic [PIXEL_BITS+3:0]      den,
  output logic [pgp_pkg::NUMF_W+((PIXEL_BITS+4 > pgp_pkg::CTR_W) ?
                 PIXEL_BITS+4 : pgp_pkg::CTR_W)-1:0] num_l,
  output logic [pgp_pkg::FOC_W+PIXEL_BITS+3:0] den_l
);

  localparam int SW = PIXEL_BITS + 4;
  localparam int AW = (SW > pgp_pkg::CTR_W) ? SW : pgp_pkg::CTR_W;
  localparam int NW = pgp_pkg::NUMF_W;
  localparam int LW = NW + AW;
  localparam int DW = pgp_pkg::FOC_W + SW;

  logic [AW-1:0] su, sv, cx_e, cy_e;
  logic          hz_nxt, pos_nxt;
  logic [SW-1:0] den_nxt;
  logic [AW-1:0] adu_nxt;
  logic [pgp_pkg::FOC_W-1:0] fx_eff;

  pgp_pkg::ctl_t ctl_a_r, ctl_b_r, ctl_c_r;
  logic [SW-1:0] den_a_r, den_b_r, den_c_r;
  logic [AW-1:0] adu_a_r, adu_b_r;
  logic [NW-1:0] numf_b_r, numf_c_r;
  logic [DW-1:0] dd_b_r, dd_c_r;
  logic [LW-1:0] nl_c_r;

  always_comb begin
    su = AW'({pix_u, 4'b0000});
    sv = AW'({pix_v, 4'b0000});
    cx_e = AW'(cfg.cx);
    cy_e = AW'(cfg.cy);
    hz_nxt = (sv <= cy_e);
    den_nxt = SW'(sv - cy_e);
    pos_nxt = (su > cx_e);
    adu_nxt = pos_nxt ? (su - cx_e) : (cx_e - su);
    fx_eff = (cfg.fx == '0) ? pgp_pkg::FOC_W'(1) : cfg.fx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      ctl_a_r <= '{valid: acc && cfg.cam_rdy, hz: hz_nxt, du_pos: pos_nxt};
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    den_a_r  <= den_nxt;
    adu_a_r  <= adu_nxt;
    numf_b_r <= NW'(cfg.h) * NW'(cfg.fy);
    dd_b_r   <= DW'(fx_eff) * DW'(den_a_r);
    den_b_r  <= den_a_r;
    adu_b_r  <= adu_a_r;
    nl_c_r   <= LW'(numf_b_r) * LW'(adu_b_r);
    numf_c_r <= numf_b_r;
    dd_c_r   <= dd_b_r;
    den_c_r  <= den_b_r;
  end

  assign ctl   = ctl_c_r;
  assign num_f = numf_c_r;
  assign den   = den_c_r;
  assign num_l = nl_c_r;
  assign den_l = dd_c_r;

endmodule

// ----- rtl/pgp_div.sv -----
// ----------------------------------------------------------------------------
// pgp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ----------------------------------------------------------------------------
module pgp_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(num[NW-1:QW]);
    low_r[0] <= num[QW-1:0];
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= ((NW+DW)'(num[NW-1:QW]) >= (NW+DW)'(den));
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem_r[k], low_r[k][QW-1]};
      ge = (t >= {1'b0, den_r[k]});
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? DW'(t - {1'b0, den_r[k]}) : DW'(t);
      low_r[k+1] <= low_r[k] << 1;
      den_r[k+1] <= den_r[k];
      q_r[k+1]   <= {q_r[k][QW-2:0], ge};
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ----- rtl/pixel_to_ground_plane_projection_core.sv -----
// ----------------------------------------------------------------------------
// pixel_to_ground_plane_projection_core
// Flat-ground inverse perspective mapping of one pixel to millimetres.
// ----------------------------------------------------------------------------
// Input: present in_pixel_u / in_pixel_v with start; a beat is taken at every
// edge where start is high and busy is low. busy stays low, so one pixel per
// cycle streams in with no gaps.
// Config: cfg_we, cfg_index, cfg_wdata write one register per edge; the user
// must write only while the core is idle, which the block does not enforce.
// Camera ready resets to 0; while it is 0 beats are dropped. Output: out_valid
// pulses for one cycle with out_forward_mm, out_lateral_mm and out_status after
// the operand stages, dividers and output register. Results leave in order.
// Throughput is one beat per cycle: three operand stages, two 25-stage
// divider pipelines (one quotient bit per stage) and one output register.
// The receiver cannot stall; each result is shown exactly once.
// Reset (rst_n low, synchronous) clears all valid bits and restores the
// register defaults.
// ----------------------------------------------------------------------------
`include "pixel_to_ground_plane_projection_core_assert.svh"

module pixel_to_ground_plane_projection_core #(
  parameter int PIXEL_BITS = pgp_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [PIXEL_BITS-1:0]             in_pixel_u,
  input  logic [PIXEL_BITS-1:0]             in_pixel_v,
  output logic                              out_valid,
  output logic [pgp_pkg::FWD_W-1:0]         out_forward_mm,
  output logic signed [pgp_pkg::LAT_W-1:0]  out_lateral_mm,
  output logic [pgp_pkg::ST_W-1:0]          out_status,
  input  logic                              cfg_we,
  input  logic [pgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SW = PIXEL_BITS + 4;
  localparam int AW = (SW > pgp_pkg::CTR_W) ? SW : pgp_pkg::CTR_W;
  localparam int NW = pgp_pkg::NUMF_W;
  localparam int LW = NW + AW;
  localparam int DW = pgp_pkg::FOC_W + SW;
  localparam int QW = pgp_pkg::QUO_W;
  localparam int DIV_LAT = QW + 1;
  localparam int LAT = DIV_LAT + 4;

  pgp_pkg::cfg_t cfg_r;
  pgp_pkg::ctl_t f_ctl;
  pgp_pkg::ctl_t ctl_r [DIV_LAT];
  logic [NW-1:0] f_num;
  logic [SW-1:0] f_den;
  logic [LW-1:0] f_nl;
  logic [DW-1:0] f_dd;
  logic [QW-1:0] fq, lq, lim, mag;
  logic          fovf, lovf, fsat, lsat;

  logic                        out_valid_r;
  logic [pgp_pkg::FWD_W-1:0]   fwd_r, fwd_nxt;
  logic [pgp_pkg::LAT_W-1:0]   lat_r, lat_nxt;
  pgp_pkg::status_t            st_r, st_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{cam_rdy: 1'b0, fx: pgp_pkg::FOCAL_X_RST, fy: pgp_pkg::FOCAL_Y_RST,
                 cx: pgp_pkg::CENTER_X_RST, cy: pgp_pkg::CENTER_Y_RST,
                 h: pgp_pkg::HEIGHT_RST};
    end else if (cfg_we) begin
      unique case (pgp_pkg::cfg_idx_t'(cfg_index))
        pgp_pkg::CFG_CAMERA_READY: cfg_r.cam_rdy <= cfg_wdata[0];
        pgp_pkg::CFG_FOCAL_X:      cfg_r.fx <= cfg_wdata;
        pgp_pkg::CFG_FOCAL_Y:      cfg_r.fy <= cfg_wdata;
        pgp_pkg::CFG_CENTER_X:     cfg_r.cx <= cfg_wdata[pgp_pkg::CTR_W-1:0];
        pgp_pkg::CFG_CENTER_Y:     cfg_r.cy <= cfg_wdata[pgp_pkg::CTR_W-1:0];
        pgp_pkg::CFG_HEIGHT:       cfg_r.h <= cfg_wdata[pgp_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  pgp_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (start && !busy),
    .pix_u (in_pixel_u),
    .pix_v (in_pixel_v),
    .cfg   (cfg_r),
    .ctl   (f_ctl),
    .num_f (f_num),
    .den   (f_den),
    .num_l (f_nl),
    .den_l (f_dd)
  );

  pgp_div #(.NW(NW), .DW(SW), .QW(QW)) u_div_fwd (
    .clk (clk),
    .num (f_num),
    .den (f_den),
    .quo (fq),
    .ovf (fovf)
  );

  pgp_div #(.NW(LW), .DW(DW), .QW(QW)) u_div_lat (
    .clk (clk),
    .num (f_nl),
    .den (f_dd),
    .quo (lq),
    .ovf (lovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) ctl_r[i] <= '0;
    end else begin
      ctl_r[0] <= f_ctl;
      for (int i = 1; i < DIV_LAT; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  always_comb begin
    fsat = fovf || (fq > pgp_pkg::FWD_MAX);
    fwd_nxt = fsat ? pgp_pkg::FWD_MAX[pgp_pkg::FWD_W-1:0] : fq[pgp_pkg::FWD_W-1:0];
    lim = ctl_r[DIV_LAT-1].du_pos ? pgp_pkg::LAT_NEG_MAX : pgp_pkg::LAT_POS_MAX;
    lsat = lovf || (lq > lim);
    mag = lsat ? lim : lq;
    lat_nxt = ctl_r[DIV_LAT-1].du_pos ? pgp_pkg::LAT_W'(-mag) : pgp_pkg::LAT_W'(mag);
    st_nxt = (fsat || lsat) ? pgp_pkg::ST_SAT : pgp_pkg::ST_OK;
    if (ctl_r[DIV_LAT-1].hz) begin
      fwd_nxt = '0;
      lat_nxt = '0;
      st_nxt = pgp_pkg::ST_HORIZON;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_r[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    lat_r <= lat_nxt;
    st_r  <= st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_forward_mm = fwd_r;
  assign out_lateral_mm = lat_r;
  assign out_status     = st_r;

  `PGP_ASSERT(a_beat_latency, clk, rst_n, out_valid |-> $past(start && !busy && cfg_r.cam_rdy, LAT), "result without matching input beat")
  `PGP_ASSERT(a_horizon_zero, clk, rst_n, (out_valid && out_status == pgp_pkg::ST_HORIZON) |-> (out_forward_mm == '0 && out_lateral_mm == '0), "horizon result not zeroed")
  `PGP_ASSERT(a_sat_clamped, clk, rst_n, (out_valid && out_status == pgp_pkg::ST_SAT) |-> (out_forward_mm == pgp_pkg::FWD_MAX[pgp_pkg::FWD_W-1:0] || out_lateral_mm == pgp_pkg::LAT_POS_MAX || out_lateral_mm == pgp_pkg::LAT_NEG_MAX), "saturated result not at a limit")

endmodule
